### rtl/swm_pkg.sv
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]           win_size_t;

  // largest signed sample, value of the running minimum with no full window
  localparam sample_t SAMPLE_MAX = sample_t'(32'sh7FFF_FFFF);

  localparam win_size_t WINDOW_SIZE_RESET = win_size_t'(4);

endpackage

`default_nettype wire

### rtl/sliding_window_minimum.sv
`default_nettype none

// sliding window minimum over a stream of signed 32-bit samples. one sample
// is taken per clock unless stalled; each gives one result via the select
// and output registers: whether a full window of window_size samples of this
// sequence has arrived, the minimum of the newest window_size samples (0
// while not full), and the running minimum of all window minimums of the
// sequence (2147483647 while none). a sample flagged last_sample closes
// the sequence after its own result. the state is a row of WINDOW_MAX
// compare cells: cell i holds the minimum of the i+1 newest samples and
// all cells update on every input transfer, so the rate is set by one
// compare per cell. the user writes window_size via the cfg port only while
// the block is idle, unenforced; zero acts as one, larger as WINDOW_MAX.
module sliding_window_minimum #(
  parameter int WINDOW_MAX = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  // configuration
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  swm_pkg::win_size_t   window_size,
  // input channel
  input  wire                  in_valid,
  output logic                 in_stall,
  input  swm_pkg::sample_t     sample,
  input  wire                  last_sample,
  // output channel
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic                 window_full,
  output swm_pkg::sample_t     window_min,
  output swm_pkg::sample_t     overall_min,
  output logic                 sequence_end
);

  import swm_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int KW = (CW > CFG_W) ? CW : CFG_W;
  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  // configuration register
  win_size_t win_size;

  // sample count of the current sequence, saturating
  logic [CW-1:0] seen;
  logic [CW-1:0] seen_inc;

  // select stage, holds one transfer between the cells and the output
  logic          a_valid;
  logic          a_full;
  logic          a_last;
  logic [IW-1:0] a_kidx;

  logic          in_accept;
  logic          a_move;

  logic [KW-1:0] k_eff;
  logic [KW-1:0] ws_ext;
  logic          full_now;

  sample_t       span_min [WINDOW_MAX];
  sample_t       sel_min;
  sample_t       running_min;
  sample_t       overall_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size <= WINDOW_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      win_size <= window_size;
    end
  end

  // handshake: select stage advances when the output register is free
  assign a_move    = !out_valid || !out_stall;
  assign in_stall  = a_valid && !a_move;
  assign in_accept = in_valid && !in_stall;

  // effective window length, clamped to one..WINDOW_MAX
  always_comb begin
    ws_ext = KW'(win_size);
    if (ws_ext == '0) begin
      k_eff = KW'(1);
    end else if (ws_ext > KW'(WINDOW_MAX)) begin
      k_eff = KW'(WINDOW_MAX);
    end else begin
      k_eff = ws_ext;
    end
    seen_inc = (seen < CW'(WINDOW_MAX)) ? seen + CW'(1) : seen;
    full_now = (KW'(seen_inc) >= k_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (in_accept) begin
      seen <= last_sample ? '0 : seen_inc;
    end
  end

  // row of cells, all updated on every input transfer
  swm_chain #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_chain (
    .clk      (clk),
    .shift    (in_accept),
    .sample   (sample),
    .span_min (span_min)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_full <= full_now;
      a_last <= last_sample;
      a_kidx <= IW'(k_eff - KW'(1));
    end
  end

  // pick the cell spanning exactly the window, fold into the running minimum
  always_comb begin
    sel_min      = span_min[a_kidx];
    overall_next = running_min;
    if (a_full && (sel_min < running_min)) begin
      overall_next = sel_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= SAMPLE_MAX;
    end else if (a_valid && a_move) begin
      running_min <= a_last ? SAMPLE_MAX : overall_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_valid && a_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_move) begin
      window_full  <= a_full;
      window_min   <= a_full ? sel_min : '0;
      overall_min  <= overall_next;
      sequence_end <= a_last;
    end
  end

endmodule

`default_nettype wire

### rtl/swm_cell.sv
`default_nettype none

module swm_cell (
  input  wire             clk,
  input  wire             shift,
  input  swm_pkg::sample_t sample,
  input  swm_pkg::sample_t prev_min,
  output swm_pkg::sample_t cell_min
);

  import swm_pkg::*;

  sample_t cell_min_next;

  // min over this cell's span: neighbour's span plus the newest sample
  always_comb begin
    cell_min_next = (sample < prev_min) ? sample : prev_min;
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      cell_min <= cell_min_next;
    end
  end

endmodule

`default_nettype wire

### rtl/swm_chain.sv
`default_nettype none

module swm_chain #(
  parameter int WINDOW_MAX = 64
) (
  input  wire              clk,
  input  wire              shift,
  input  swm_pkg::sample_t sample,
  output swm_pkg::sample_t span_min [WINDOW_MAX]
);

  import swm_pkg::*;

  genvar g;
  generate
    for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
      if (g == 0) begin : g_head
        // first cell spans only the newest sample
        swm_cell u_cell (
          .clk      (clk),
          .shift    (shift),
          .sample   (sample),
          .prev_min (sample),
          .cell_min (span_min[g])
        );
      end else begin : g_body
        swm_cell u_cell (
          .clk      (clk),
          .shift    (shift),
          .sample   (sample),
          .prev_min (span_min[g-1]),
          .cell_min (span_min[g])
        );
      end
    end
  endgenerate

endmodule

`default_nettype wire

### sim/sliding_window_minimum_tb.sv
`default_nettype none

module sliding_window_minimum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  localparam int WINDOW_MAX   = 64;
  localparam int RANDOM_ITEMS = 600;

  // most negative sample
  localparam sample_t SAMPLE_MIN = sample_t'(32'sh8000_0000);

  // one predicted result, field for field as the output channel carries it
  typedef struct {
    logic    full;
    sample_t wmin;
    sample_t omin;
    logic    seq_end;
  } minima_t;

  // clock and reset
  logic clk;
  logic rst = 1'b1;

  // configuration channel
  logic      cfg_valid   = 1'b0;
  logic      cfg_ready;
  win_size_t window_size = WINDOW_SIZE_RESET;

  // input channel
  logic    in_valid    = 1'b0;
  logic    in_stall;
  sample_t sample      = '0;
  logic    last_sample = 1'b0;

  // output channel
  logic    out_valid;
  logic    out_stall = 1'b0;
  logic    window_full;
  sample_t window_min;
  sample_t overall_min;
  logic    sequence_end;

  // when set, neither side idles: gives a long gap-free stretch
  logic quiet = 1'b0;

  // predicted results, oldest first
  minima_t minima_due [$];

  // predictor state: sample history, write slot, samples of this sequence,
  // running minimum of window minimums and the window size last written
  sample_t     hist [WINDOW_MAX];
  int unsigned hist_wp;
  int unsigned seq_count;
  sample_t     seq_min;
  win_size_t   win_cfg;

  // run statistics
  int items_sent   = 0;
  int results_seen = 0;
  int seqs_closed  = 0;
  int cfg_writes   = 0;
  int err_count    = 0;

  sliding_window_minimum #(
    .WINDOW_MAX(WINDOW_MAX)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .window_size (window_size),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .window_full (window_full),
    .window_min  (window_min),
    .overall_min (overall_min),
    .sequence_end(sequence_end)
  );

  // 4 ns clock, low for the first half period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver backpressure, changed only on the falling edge
  always @(negedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 18);
  end

  // size actually used: zero behaves as one, anything above the depth saturates
  function automatic int unsigned effective_size(win_size_t w);
    if (w == 0)
      return 1;
    if (w > WINDOW_MAX)
      return WINDOW_MAX;
    return w;
  endfunction

  // advance the predictor by one accepted sample and return its result
  function automatic minima_t predict_minima(sample_t s, logic last);
    minima_t     r;
    int unsigned eff;
    int unsigned idx;
    eff = effective_size(win_cfg);
    hist[hist_wp] = s;
    hist_wp = (hist_wp + 1) % WINDOW_MAX;
    if (seq_count < WINDOW_MAX)
      seq_count++;
    r.full = (seq_count >= eff);
    // window not yet full: minimum reads zero, running minimum untouched
    r.wmin = '0;
    if (r.full) begin
      r.wmin = SAMPLE_MAX;
      for (int i = 0; i < eff; i++) begin
        idx = (hist_wp + WINDOW_MAX - 1 - i) % WINDOW_MAX;
        if (hist[idx] < r.wmin)
          r.wmin = hist[idx];
      end
      if (r.wmin < seq_min)
        seq_min = r.wmin;
    end
    r.omin = seq_min;
    r.seq_end = last;
    // last sample closes the sequence after its own result
    if (last) begin
      seq_count = 0;
      seq_min = SAMPLE_MAX;
    end
    return r;
  endfunction

  // mix of extremes, near-extremes, small values (plenty of ties) and full range
  function automatic sample_t random_sample();
    case ($urandom_range(0, 11))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return sample_t'(SAMPLE_MAX - sample_t'($urandom_range(0, 3)));
      3:       return sample_t'(SAMPLE_MIN + sample_t'($urandom_range(0, 3)));
      4, 5, 6: return sample_t'(sample_t'($urandom_range(0, 16)) - sample_t'(8));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // one input transfer; called and returns on a falling edge
  task automatic send_item(sample_t s, logic last);
    while (!quiet && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    last_sample <= last;
    do
      @(posedge clk);
    while (in_stall);
    minima_due.push_back(predict_minima(s, last));
    items_sent++;
    if (last)
      seqs_closed++;
    @(negedge clk);
  endtask

  // hold off the sender until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (minima_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // register write, only once the block has drained
  task automatic write_window(win_size_t w);
    wait_idle();
    cfg_valid <= 1'b1;
    window_size <= w;
    do
      @(posedge clk);
    while (!cfg_ready);
    win_cfg = w;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reset window of four, extremes of the sample range, a closed sequence
  task automatic test_reset_window();
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(sample_t'(0), 1'b0);
    send_item(sample_t'(-1), 1'b0);
    send_item(sample_t'(5), 1'b1);
  endtask

  // sequence that ends before its window ever fills
  task automatic test_short_sequence();
    send_item(sample_t'(-7), 1'b0);
    send_item(SAMPLE_MIN, 1'b1);
  endtask

  // size zero behaves as a window of one
  task automatic test_size_zero();
    write_window(win_size_t'(0));
    send_item(sample_t'(3), 1'b0);
    send_item(sample_t'(9), 1'b0);
    send_item(sample_t'(-2), 1'b1);
  endtask

  // window of one over the largest sample: running minimum stays at its top
  task automatic test_size_one();
    write_window(win_size_t'(1));
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MAX, 1'b1);
  endtask

  // size raised while a sequence is open: new size applies to the next sample
  task automatic test_size_change_mid_sequence();
    write_window(win_size_t'(3));
    send_item(sample_t'(10), 1'b0);
    send_item(sample_t'(-4), 1'b0);
    send_item(sample_t'(6), 1'b0);
    send_item(sample_t'(8), 1'b0);
    write_window(win_size_t'(6));
    send_item(sample_t'(1), 1'b0);
    send_item(sample_t'(2), 1'b0);
    send_item(sample_t'(-3), 1'b1);
  endtask

  // size beyond the buffer depth saturates
  task automatic test_size_above_max();
    write_window(win_size_t'(127));
    send_item(sample_t'(1), 1'b0);
    send_item(sample_t'(-1), 1'b0);
    send_item(sample_t'(0), 1'b1);
  endtask

  // random phases: each writes a size then sends a few sequences, most long
  // enough to fill the window, some cut short, a few with a stray last flag
  task automatic test_random_sequences();
    int          start;
    int          phase;
    int          len;
    int unsigned eff;
    int unsigned pick;
    win_size_t   w;
    logic        last;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (phase == 1)
        w = win_size_t'(5);
      else if (phase == 2)
        w = win_size_t'(127);
      else if (phase == 3)
        w = win_size_t'(WINDOW_MAX);
      else if (pick < 6)
        w = win_size_t'(0);
      else if (pick < 10)
        w = win_size_t'(WINDOW_MAX);
      else
        w = win_size_t'($urandom_range(1, 12));
      write_window(w);
      // one phase with no idling on either side
      quiet = (phase == 1);
      eff = effective_size(w);
      repeat ($urandom_range(2, 4)) begin
        if (phase == 1)
          len = 40;
        else if ($urandom_range(0, 9) < 2)
          len = $urandom_range(1, eff);
        else
          len = $urandom_range(eff, eff + 20);
        for (int i = 0; i < len; i++) begin
          // occasional drain in the middle of a sequence
          if (i > 0 && $urandom_range(0, 99) == 0)
            wait_idle();
          last = (i == len - 1) || ($urandom_range(0, 49) == 0);
          send_item(random_sample(), last);
        end
      end
      quiet = 1'b0;
      phase++;
    end
  endtask

  // compare every output transfer against the oldest prediction
  always @(posedge clk) begin : check_results
    minima_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (minima_due.size() == 0) begin
        $error("result transfer with no sample pending");
        err_count++;
      end else begin
        want = minima_due.pop_front();
        if (window_full !== want.full) begin
          $error("window_full: expected %0b, actual %0b", want.full, window_full);
          err_count++;
        end
        if (window_min !== want.wmin) begin
          $error("window_min: expected %0d, actual %0d", want.wmin, window_min);
          err_count++;
        end
        if (overall_min !== want.omin) begin
          $error("overall_min: expected %0d, actual %0d", want.omin, overall_min);
          err_count++;
        end
        if (sequence_end !== want.seq_end) begin
          $error("sequence_end: expected %0b, actual %0b", want.seq_end, sequence_end);
          err_count++;
        end
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", minima_due.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    // predictor starts from the reset state of the block
    foreach (hist[i])
      hist[i] = '0;
    hist_wp = 0;
    seq_count = 0;
    seq_min = SAMPLE_MAX;
    win_cfg = WINDOW_SIZE_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_window();
    test_short_sequence();
    test_size_zero();
    test_size_one();
    test_size_change_mid_sequence();
    test_size_above_max();
    test_random_sequences();

    wait_idle();
    repeat (10) @(posedge clk);
    if (minima_due.size() != 0) begin
      $error("%0d predicted results never arrived", minima_due.size());
      err_count += minima_due.size();
    end

    $display("sent %0d samples in %0d closed sequences, checked %0d results",
             items_sent, seqs_closed, results_seen);
    $display("window size written %0d times, including zero, one, 64 and 127",
             cfg_writes);
    if (err_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
